>>> hdl/wsd_pkg.sv
// Package for the websocket frame deframer: parser phases and header constants.
package wsd_pkg;

  typedef enum logic [4:0] {
    PH_HDR0    = 5'b00001,
    PH_HDR1    = 5'b00010,
    PH_EXTLEN  = 5'b00100,
    PH_KEY     = 5'b01000,
    PH_PAYLOAD = 5'b10000
  } phase_e;

  localparam logic [7:0] MASK_BIT    = 8'h80;
  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [2:0] CNT_EXT16   = 3'd1;
  localparam logic [2:0] CNT_EXT64   = 3'd7;
  localparam logic [2:0] CNT_KEY     = 3'd3;

endpackage

>>> hdl/websocket_frame_deframer_unit.sv
// Websocket frame deframer top level: header stripping and payload unmasking.
//
//   channel   dir  fields (tdata low bit up)       tlast         tuser
//   s_axis    in   in_byte[7:0]                    buffer_last   -
//   m_axis    out  payload_byte[7:0]               frame_last    buffer_end
//
// One byte is accepted per cycle unless the output stalls; each accepted payload byte appears
// at the output register in the next cycle. Header, extended length and key bytes produce no item.
// The parser state and the output register update in the same cycle of acceptance.
// Reset returns the parser to the first header byte and empties the output register.
// A stalled output holds its item; the input is still taken when the output drains
// in the same cycle.
module websocket_frame_deframer_unit #(
  parameter int LENGTH_BITS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // in_byte
  input  logic       s_axis_tlast_i,   // buffer_last
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // payload_byte
  output logic       m_axis_tlast_o,   // frame_last
  output logic       m_axis_tuser_o    // buffer_end
);

  wsd_pkg::phase_e        phase_q, phase_d;
  logic [2:0]             cnt_q, cnt_d;
  logic [LENGTH_BITS-1:0] rem_q, rem_d;
  logic [31:0]            key_q, key_d;
  logic                   masked_q, masked_d;
  logic [1:0]             kidx_q, kidx_d;

  logic                   out_valid_q;
  logic [7:0]             out_data_q;
  logic                   out_last_q;
  logic                   out_user_q;

  logic                   s_accept;
  logic                   emit;
  logic [7:0]             key_byte;
  logic [6:0]             code;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign code            = s_axis_tdata_i[6:0];

  always_comb begin
    case (kidx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    key_d    = key_q;
    masked_d = masked_q;
    kidx_d   = kidx_q;
    emit     = 1'b0;
    unique case (phase_q)
      wsd_pkg::PH_HDR1: begin
        masked_d = (s_axis_tdata_i & wsd_pkg::MASK_BIT) != 8'h00;
        if (code == wsd_pkg::LEN_CODE_16) begin
          rem_d   = '0;
          cnt_d   = wsd_pkg::CNT_EXT16;
          phase_d = wsd_pkg::PH_EXTLEN;
        end else if (code == wsd_pkg::LEN_CODE_64) begin
          rem_d   = '0;
          cnt_d   = wsd_pkg::CNT_EXT64;
          phase_d = wsd_pkg::PH_EXTLEN;
        end else begin
          rem_d = {{(LENGTH_BITS-7){1'b0}}, code};
          if (masked_d) begin
            phase_d = wsd_pkg::PH_KEY;
            cnt_d   = wsd_pkg::CNT_KEY;
          end else begin
            kidx_d  = 2'd0;
            phase_d = (rem_d == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsd_pkg::PH_EXTLEN: begin
        if (rem_q[LENGTH_BITS-1 -: 8] != 8'h00) begin
          rem_d = '1;
        end else begin
          rem_d = {rem_q[LENGTH_BITS-9:0], s_axis_tdata_i};
        end
        if (cnt_q == 3'd0) begin
          if (masked_q) begin
            phase_d = wsd_pkg::PH_KEY;
            cnt_d   = wsd_pkg::CNT_KEY;
          end else begin
            kidx_d  = 2'd0;
            phase_d = (rem_d == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d = {key_q[23:0], s_axis_tdata_i};
        if (cnt_q == 3'd0) begin
          kidx_d  = 2'd0;
          phase_d = (rem_q == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
        end else begin
          cnt_d = cnt_q - 3'd1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        emit   = 1'b1;
        kidx_d = kidx_q + 2'd1;
        rem_d  = rem_q - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        if (rem_d == '0) begin
          phase_d = wsd_pkg::PH_HDR0;
        end
      end
      default: begin
        phase_d = wsd_pkg::PH_HDR1;
      end
    endcase
    if (s_axis_tlast_i) begin
      phase_d = wsd_pkg::PH_HDR0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsd_pkg::PH_HDR0;
      cnt_q    <= '0;
      rem_q    <= '0;
      key_q    <= '0;
      masked_q <= 1'b0;
      kidx_q   <= '0;
    end else if (s_accept) begin
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      rem_q    <= rem_d;
      key_q    <= key_d;
      masked_q <= masked_d;
      kidx_q   <= kidx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      out_valid_q <= s_accept && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept && emit) begin
      out_data_q <= masked_q ? (s_axis_tdata_i ^ key_byte) : s_axis_tdata_i;
      out_last_q <= rem_q == {{(LENGTH_BITS-1){1'b0}}, 1'b1};
      out_user_q <= s_axis_tlast_i;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_user_q;

  a_last_resets_parser: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s_axis_tlast_i |=> phase_q == wsd_pkg::PH_HDR0)
    else $error("buffer end did not return parser to first header byte");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == wsd_pkg::PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero remaining length");

  a_frame_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && phase_q == wsd_pkg::PH_PAYLOAD &&
    rem_q == {{(LENGTH_BITS-1){1'b0}}, 1'b1} |=> phase_q == wsd_pkg::PH_HDR0)
    else $error("parser did not leave payload after final byte");

  a_header_no_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && phase_q != wsd_pkg::PH_PAYLOAD |=> !out_valid_q)
    else $error("header byte produced an output item");

endmodule

>>> tb/testbench.sv
// Testbench for the websocket frame deframer: directed and random framed byte streams checked by a scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam int LEN_W = 64;

  typedef struct packed {
    logic [7:0] payload;
    logic       frame_last;
    logic       buffer_end;
  } payload_item_t;

  typedef enum logic [1:0] {
    FORM_7,
    FORM_16,
    FORM_64
  } len_form_e;

  class deframe_scoreboard;
    wsd_pkg::phase_e   phase   = wsd_pkg::PH_HDR0;
    logic [2:0]        count   = '0;
    logic [LEN_W-1:0]  rem_len = '0;
    logic [31:0]       key     = '0;
    logic              masked  = 1'b0;
    logic [1:0]        key_idx = '0;
    payload_item_t     payload_q[$];
    int                fail_count = 0;

    function int pending();
      return payload_q.size();
    endfunction

    function void flag(string what, payload_item_t want, payload_item_t got);
      fail_count++;
      if (fail_count <= 10) begin
        $display("%0t %s: expected byte %02h frame_last %0b buffer_end %0b,",
                 $time, what, want.payload, want.frame_last, want.buffer_end);
        $display("    got byte %02h frame_last %0b buffer_end %0b",
                 got.payload, got.frame_last, got.buffer_end);
      end
    endfunction

    function void start_payload();
      key_idx = '0;
      phase = (rem_len == '0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
    endfunction

    function void length_done();
      if (masked) begin
        phase = wsd_pkg::PH_KEY;
        count = wsd_pkg::CNT_KEY;
      end else begin
        start_payload();
      end
    endfunction

    function void deframe_byte(logic [7:0] b, logic last);
      logic [7:0]    key_byte;
      payload_item_t item;
      case (phase)
        wsd_pkg::PH_HDR1: begin
          masked = ((b & wsd_pkg::MASK_BIT) != 8'h00);
          if (b[6:0] == wsd_pkg::LEN_CODE_16) begin
            rem_len = '0;
            count = wsd_pkg::CNT_EXT16;
            phase = wsd_pkg::PH_EXTLEN;
          end else if (b[6:0] == wsd_pkg::LEN_CODE_64) begin
            rem_len = '0;
            count = wsd_pkg::CNT_EXT64;
            phase = wsd_pkg::PH_EXTLEN;
          end else begin
            rem_len = LEN_W'(b[6:0]);
            length_done();
          end
        end
        wsd_pkg::PH_EXTLEN: begin
          if (rem_len[LEN_W-1 -: 8] != 8'h00) rem_len = '1;
          else rem_len = {rem_len[LEN_W-9:0], b};
          if (count == 3'd0) length_done();
          else count = count - 3'd1;
        end
        wsd_pkg::PH_KEY: begin
          key = {key[23:0], b};
          if (count == 3'd0) start_payload();
          else count = count - 3'd1;
        end
        wsd_pkg::PH_PAYLOAD: begin
          key_byte = masked ? key[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
          item.payload    = b ^ key_byte;
          item.frame_last = (rem_len == LEN_W'(1));
          item.buffer_end = last;
          payload_q.push_back(item);
          key_idx = key_idx + 2'd1;
          rem_len = rem_len - LEN_W'(1);
          if (rem_len == '0) phase = wsd_pkg::PH_HDR0;
        end
        default: begin
          phase = wsd_pkg::PH_HDR1;
        end
      endcase
      if (last) phase = wsd_pkg::PH_HDR0;
    endfunction

    function void check_payload(payload_item_t got);
      payload_item_t want;
      if (payload_q.size() == 0) begin
        flag("unexpected item", '0, got);
      end else begin
        want = payload_q.pop_front();
        if (got.payload !== want.payload || got.frame_last !== want.frame_last ||
            got.buffer_end !== want.buffer_end) begin
          flag("mismatch", want, got);
        end
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       s_axis_tvalid_i;
  logic       s_axis_tready_o;
  logic [7:0] s_axis_tdata_i;   // in_byte
  logic       s_axis_tlast_i;   // buffer_last
  logic       m_axis_tvalid_o;
  logic       m_axis_tready_i;
  logic [7:0] m_axis_tdata_o;   // payload_byte
  logic       m_axis_tlast_o;   // frame_last
  logic       m_axis_tuser_o;   // buffer_end

  deframe_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int bytes_sent = 0;

  websocket_frame_deframer_unit #(
    .LENGTH_BITS(LEN_W)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_payload({m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o});
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        sb.deframe_byte(s_axis_tdata_i, s_axis_tlast_i);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= b;
    s_axis_tlast_i  <= last;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Build one frame, optionally cut short by a buffer end at byte index cut.
  task automatic send_frame(input logic [63:0] length, input len_form_e form, input logic masked,
                            input int cut, input logic close_buffer);
    logic [7:0]  frame_q[$];
    logic [31:0] key;
    int          n_payload;
    int          stop;
    logic        end_mark;
    key = $urandom;
    frame_q.push_back(8'($urandom_range(255)));
    case (form)
      FORM_7: begin
        frame_q.push_back({masked, length[6:0]});
      end
      FORM_16: begin
        frame_q.push_back({masked, wsd_pkg::LEN_CODE_16});
        frame_q.push_back(length[15:8]);
        frame_q.push_back(length[7:0]);
      end
      default: begin
        frame_q.push_back({masked, wsd_pkg::LEN_CODE_64});
        for (int i = 7; i >= 0; i--) frame_q.push_back(length[8 * i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) frame_q.push_back(key[8 * i +: 8]);
    end
    n_payload = (length > 64'd200) ? 200 : int'(length);
    repeat (n_payload) frame_q.push_back(8'($urandom_range(255)));
    stop = (cut >= 0 && cut < frame_q.size()) ? cut : frame_q.size() - 1;
    end_mark = close_buffer || (stop != frame_q.size() - 1);
    for (int i = 0; i <= stop; i++) send_byte(frame_q[i], (i == stop) && end_mark);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int target);
    int        pick;
    int        sel;
    int        n;
    logic      masked;
    len_form_e form;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    while (bytes_sent < target) begin
      pick   = $urandom_range(99);
      masked = 1'($urandom_range(1));
      if (pick < 60) begin
        sel  = $urandom_range(9);
        form = (sel < 7) ? FORM_7 : (sel < 9) ? FORM_16 : FORM_64;
        send_frame(($urandom_range(9) == 0) ? 64'($urandom_range(125))
                                            : 64'($urandom_range(12)),
                   form, masked, -1, 1'($urandom_range(1)));
      end else if (pick < 75) begin
        if ($urandom_range(1)) begin
          send_frame(64'($urandom_range(65535, 126)), FORM_16, masked,
                     $urandom_range(30), 1'b1);
        end else begin
          send_frame({$urandom, $urandom}, FORM_64, masked, $urandom_range(30), 1'b1);
        end
      end else if (pick < 85) begin
        send_frame(64'($urandom_range(12)), FORM_7, masked, $urandom_range(5), 1'b1);
      end else if (pick < 95) begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) begin
          send_byte(8'($urandom_range(255)), (i == n - 1) ? 1'b1 : 1'($urandom_range(1)));
        end
      end else begin
        send_frame(64'd0, FORM_7, masked, -1, 1'b1);
      end
    end
    drain();
  endtask

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int wait_cycles;
    sb = new;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= 8'h00;
    s_axis_tlast_i  <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // masked frame with 16-bit length, payload continues the buffer
    send_byte(8'h81, 1'b0);
    send_byte({wsd_pkg::MASK_BIT[7], wsd_pkg::LEN_CODE_16}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h3C, 1'b0);
    // zero-length frame closing the buffer
    send_byte(8'h82, 1'b0);
    send_byte(8'h00, 1'b1);
    // 64-bit length of all ones, buffer ends after one payload byte
    send_byte(8'h02, 1'b0);
    send_byte({1'b0, wsd_pkg::LEN_CODE_64}, 1'b0);
    repeat (8) send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b1);
    // buffer ends on the first header byte
    send_byte(8'h01, 1'b1);
    drain();

    run_phase(0, 0, bytes_sent + 425);
    run_phase(76, 0, bytes_sent + 425);
    run_phase(0, 76, bytes_sent + 425);
    run_phase(27, 27, bytes_sent + 425);

    recv_stall_pct = 0;
    wait_cycles = 0;
    while (sb.pending() != 0 && wait_cycles < 2000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (4) @(posedge clk_i);
    if (sb.pending() != 0) sb.flag("item never arrived", sb.payload_q[0], '0);
    if (sb.fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
